// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: property failed");

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== rtl/cba_pkg.sv =====
package cba_pkg;

  // request opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  localparam logic [31:0] FIRST_DATA = 32'd2;
  localparam logic [31:0] NO_CLUSTER = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_RMW
  } cba_state_t;

  // bounds of the word being looked at
  typedef struct packed {
    logic       phase2;
    logic [4:0] s_off;
    logic [4:0] last_off;
  } cba_scan_ctl_t;

  typedef struct packed {
    logic       found;
    logic [4:0] pos;
    logic [5:0] ones;
  } cba_scan_res_t;

endpackage

// ===== rtl/cba_map_ram.sv =====
module cba_map_ram import cba_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cba_word_eval.sv =====
module cba_word_eval import cba_pkg::*; #(
  parameter int AW = 11
) (
  input  logic [AW-1:0]  addr,
  input  logic [AW-1:0]  ws,
  input  logic [AW-1:0]  wl,
  input  logic [31:0]    word,
  input  cba_scan_ctl_t  ctl,
  output cba_scan_res_t  res
);

  logic [31:0] hi_mask;
  logic [31:0] lo_mask;
  logic [31:0] cand;

  // hi mask keeps bits below the data limit, lo mask keeps the scan window
  always_comb begin
    if (addr < wl) begin
      hi_mask = '1;
    end else if (addr == wl) begin
      hi_mask = 32'hFFFF_FFFF >> (5'd31 - ctl.last_off);
    end else begin
      hi_mask = '0;
    end
    if (!ctl.phase2) begin
      if (addr > ws) begin
        lo_mask = '1;
      end else if (addr == ws) begin
        lo_mask = 32'hFFFF_FFFF << ctl.s_off;
      end else begin
        lo_mask = '0;
      end
    end else begin
      if (addr < ws) begin
        lo_mask = '1;
      end else if (addr == ws) begin
        lo_mask = ~(32'hFFFF_FFFF << ctl.s_off);
      end else begin
        lo_mask = '0;
      end
    end
  end

  assign cand = ~word & hi_mask & lo_mask;

  // lowest free bit in the window
  always_comb begin
    res.found = |cand;
    res.pos   = '0;
    for (int b = 31; b >= 0; b--) begin
      if (cand[b]) begin
        res.pos = 5'(b);
      end
    end
    res.ones = 6'($countones(word & hi_mask));
  end

endmodule

// ===== rtl/cluster_bitmap_allocator_core.sv =====
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------
// request   | start, busy        | opcode, cluster, hint, byte_index, byte_value
// result    | done (one cycle)   | status, result_cluster, used_total
// config    | cfg_we             | cfg_data (cluster total)
//
// a request is taken when start is high and busy low; one request at a time
// alloc: reads words of 32 bits from the bitmap ram, one word per cycle, from the start
//   word up to the data limit, then from word 0 round to the start word
// count: reads every word up to the data limit; free and load: a read, then a write
// after reset the bitmap ram is cleared one word a cycle, ceil(MAX/32)
//   words (2048 by default), with busy high; config writes still land
// done pulses for one cycle; the receiver cannot stall results
module cluster_bitmap_allocator_core import cba_pkg::*; #(
  parameter int MAX_DATA_CLUSTERS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] cluster,
  input  logic [31:0] hint,
  input  logic [12:0] byte_index,
  input  logic [7:0]  byte_value,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] result_cluster,
  output logic [16:0] used_total
);

`include "assert_macros.svh"

  // bitmap geometry
  localparam int WORDS     = (MAX_DATA_CLUSTERS + 31) / 32;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW        = AW + 5;
  localparam int DW        = $clog2(MAX_DATA_CLUSTERS + 1);
  localparam int CW0       = (DW > IW) ? DW : IW;
  localparam int CW        = ((CW0 > 17) ? CW0 : 17) + 1;
  localparam int MAP_BYTES = (MAX_DATA_CLUSTERS + 7) / 8;
  localparam int RESET_D   = (MAX_DATA_CLUSTERS < 65536) ? MAX_DATA_CLUSTERS : 65536;

  localparam logic [AW-1:0] LAST_WORD  = AW'(WORDS - 1);
  localparam logic [CW-1:0] MAX_D      = CW'(MAX_DATA_CLUSTERS);
  localparam logic [CW-1:0] RESET_DATA = CW'(RESET_D);

  cba_state_t state, state_next;

  // control and bookkeeping
  logic [CW-1:0] data_cnt;      // data clusters after clamping
  logic [16:0]   used_count;
  logic [IW-1:0] sp_idx;        // search pointer as bit index
  logic [1:0]    op_q;

  // scan window
  logic [AW-1:0] ws;
  logic [4:0]    s_off;
  logic [AW-1:0] wl;
  logic [4:0]    last_off;

  // read pipeline
  logic [AW-1:0] scan_addr;
  logic          issue_phase;
  logic          issue_on;
  logic          rd_valid;
  logic [AW-1:0] rd_word_addr;
  logic          rd_phase;

  // read-modify-write of one word
  logic [AW-1:0] rmw_addr;
  logic [4:0]    rmw_bit;
  logic [1:0]    rmw_lane;
  logic [7:0]    rmw_byte;
  logic [CW-1:0] acc;

  // result registers
  logic [1:0]    res_status;
  logic [31:0]   res_cluster;
  logic [16:0]   res_used;

  // ram port
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  // request decode
  logic [31:0]   hint_idx;
  logic          hint_ok;
  logic          sp_ok;
  logic [IW-1:0] start_idx;
  logic [CW-1:0] last_idx_w;
  logic [IW-1:0] last_idx;
  logic          used_lt;
  logic [31:0]   cl_idx;
  logic          free_ok;
  logic          load_ok;
  logic [AW-1:0] load_word;
  logic [4:0]    lane_sh;
  logic [IW-1:0] found_idx;
  logic [CW-1:0] acc_sum;

  cba_scan_ctl_t scan_ctl;
  cba_scan_res_t scan_res;

  // clamp a written cluster total to the data cluster count
  function automatic logic [CW-1:0] clamp_data(input logic [16:0] v);
    logic [CW-1:0] t;
    t = CW'(v);
    if (t < CW'(FIRST_DATA)) begin
      t = '0;
    end else begin
      t = t - CW'(FIRST_DATA);
      if (t > MAX_D) begin
        t = MAX_D;
      end
    end
    return t;
  endfunction

  // start point: hint, then search pointer, then first data cluster
  assign hint_idx   = hint - FIRST_DATA;
  assign hint_ok    = (hint >= FIRST_DATA) && (hint_idx < 32'(data_cnt));
  assign sp_ok      = CW'(sp_idx) < data_cnt;
  assign start_idx  = hint_ok ? hint_idx[IW-1:0] : (sp_ok ? sp_idx : '0);
  assign last_idx_w = data_cnt - CW'(1);
  assign last_idx   = last_idx_w[IW-1:0];
  assign used_lt    = CW'(used_count) < data_cnt;

  // free and load address checks
  assign cl_idx    = cluster - FIRST_DATA;
  assign free_ok   = (cluster >= FIRST_DATA) && (cl_idx < 32'(data_cnt));
  assign load_ok   = 32'(byte_index) < 32'(MAP_BYTES);
  assign load_word = AW'(byte_index[12:2]);
  assign lane_sh   = {rmw_lane, 3'b000};

  assign found_idx = {rd_word_addr, scan_res.pos};
  assign acc_sum   = acc + CW'(scan_res.ones);

  assign scan_ctl.phase2   = rd_phase;
  assign scan_ctl.s_off    = s_off;
  assign scan_ctl.last_off = last_off;

  cba_map_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  cba_word_eval #(
    .AW (AW)
  ) u_eval (
    .addr (rd_word_addr),
    .ws   (ws),
    .wl   (wl),
    .word (mem_rdata),
    .ctl  (scan_ctl),
    .res  (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram port
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = scan_addr;
    mem_we     = 1'b0;
    mem_waddr  = scan_addr;
    mem_wdata  = '0;
    case (state)
      ST_CLEAR: begin
        // clearing sweep after reset
        mem_we = 1'b1;
        if (scan_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (opcode)
            OP_ALLOC: begin
              if (used_lt) begin
                state_next = ST_SCAN;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = cl_idx[IW-1:5];
                state_next = ST_RMW;
              end
            end
            OP_COUNT: begin
              if (data_cnt != '0) begin
                state_next = ST_COUNT;
              end
            end
            OP_LOAD: begin
              if (load_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = load_word;
                state_next = ST_RMW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // reads stream one word a cycle; a stale word in flight is dropped
        mem_re = issue_on;
        if (rd_valid && scan_res.found) begin
          mem_we     = 1'b1;
          mem_waddr  = rd_word_addr;
          mem_wdata  = mem_rdata | (32'd1 << scan_res.pos);
          state_next = ST_IDLE;
        end else if (rd_valid && rd_phase && rd_word_addr == ws) begin
          state_next = ST_IDLE;
        end
      end
      ST_COUNT: begin
        mem_re = issue_on;
        if (rd_valid && rd_word_addr == wl) begin
          state_next = ST_IDLE;
        end
      end
      ST_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = rmw_addr;
        if (op_q == OP_FREE) begin
          mem_wdata = mem_rdata & ~(32'd1 << rmw_bit);
        end else begin
          mem_wdata = (mem_rdata & ~(32'hFF << lane_sh)) | (32'(rmw_byte) << lane_sh);
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      rd_valid   <= 1'b0;
      issue_on   <= 1'b0;
      scan_addr  <= '0;
      used_count <= '0;
      sp_idx     <= '0;
      data_cnt   <= RESET_DATA;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      if (cfg_we) begin
        data_cnt <= clamp_data(cfg_data);
      end
      case (state)
        ST_CLEAR: begin
          scan_addr <= scan_addr + AW'(1);
        end
        ST_IDLE: begin
          if (start) begin
            op_q        <= opcode;
            ws          <= start_idx[IW-1:5];
            s_off       <= start_idx[4:0];
            wl          <= last_idx[IW-1:5];
            last_off    <= last_idx[4:0];
            acc         <= '0;
            issue_phase <= 1'b0;
            issue_on    <= 1'b1;
            rmw_addr    <= (opcode == OP_FREE) ? cl_idx[IW-1:5] : load_word;
            rmw_bit     <= cl_idx[4:0];
            rmw_lane    <= byte_index[1:0];
            rmw_byte    <= byte_value;
            res_status  <= STATUS_OK;
            res_cluster <= '0;
            res_used    <= used_count;
            case (opcode)
              OP_ALLOC: begin
                scan_addr <= start_idx[IW-1:5];
                // count says full: answer without scanning
                if (!used_lt) begin
                  done        <= 1'b1;
                  res_status  <= STATUS_NO_SPACE;
                  res_cluster <= NO_CLUSTER;
                end
              end
              OP_FREE: begin
                if (!free_ok) begin
                  done       <= 1'b1;
                  res_status <= STATUS_RANGE;
                end
              end
              OP_COUNT: begin
                scan_addr <= '0;
                if (data_cnt == '0) begin
                  done     <= 1'b1;
                  res_used <= '0;
                end
              end
              OP_LOAD: begin
                // byte beyond the bitmap: nothing written
                if (!load_ok) begin
                  done <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // first pass start..limit, then wrap from word 0 back to start
          if (issue_on) begin
            rd_valid     <= 1'b1;
            rd_word_addr <= scan_addr;
            rd_phase     <= issue_phase;
            if (!issue_phase && scan_addr == wl) begin
              issue_phase <= 1'b1;
              scan_addr   <= '0;
            end else if (issue_phase && scan_addr == ws) begin
              issue_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + AW'(1);
            end
          end
          if (rd_valid && scan_res.found) begin
            done        <= 1'b1;
            rd_valid    <= 1'b0;
            res_cluster <= 32'(found_idx) + FIRST_DATA;
            used_count  <= used_count + 17'd1;
            res_used    <= used_count + 17'd1;
            sp_idx      <= found_idx;
          end else if (rd_valid && rd_phase && rd_word_addr == ws) begin
            done        <= 1'b1;
            res_status  <= STATUS_NO_SPACE;
            res_cluster <= NO_CLUSTER;
          end
        end
        ST_COUNT: begin
          if (issue_on) begin
            rd_valid     <= 1'b1;
            rd_word_addr <= scan_addr;
            rd_phase     <= 1'b0;
            if (scan_addr == wl) begin
              issue_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + AW'(1);
            end
          end
          if (rd_valid) begin
            acc <= acc_sum;
            if (rd_word_addr == wl) begin
              done     <= 1'b1;
              res_used <= acc_sum[16:0];
            end
          end
        end
        ST_RMW: begin
          done <= 1'b1;
          // free of a clear bit still drops the count, floor at zero
          if (op_q == OP_FREE && used_count != '0) begin
            used_count <= used_count - 17'd1;
            res_used   <= used_count - 17'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy           = (state != ST_IDLE);
  assign status         = res_status;
  assign result_cluster = res_cluster;
  assign used_total     = res_used;

  // checks
  `ASSERT_CLK(a_nospace_cluster, clk, rst, done && status == STATUS_NO_SPACE |-> result_cluster == NO_CLUSTER)
  `ASSERT_CLK(a_rd_from_sweep, clk, rst, rd_valid |-> $past(state == ST_SCAN) || $past(state == ST_COUNT))
  `ASSERT_NEVER(a_rw_same_word, clk, rst, mem_we && mem_re && mem_waddr == mem_raddr && state != ST_SCAN)
  `ASSERT_CLK(a_done_after_work, clk, rst, done |-> $past(busy) || $past(start))

endmodule

// ===== tb/sv/tb_cluster_bitmap_allocator_core.sv =====
module tb_cluster_bitmap_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cba_pkg::*;

  // bitmap geometry at the default core parameter
  localparam int unsigned MAP_CLUSTERS = 65536;
  localparam int unsigned MAP_BYTES    = MAP_CLUSTERS / 8;
  // longest legal quiet stretch is the clear pass or a full scan
  localparam int unsigned STALL_LIMIT  = 20000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] cluster;
    logic [31:0] hint;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] cluster;
    logic [16:0] used;
  } alloc_reply_t;

  // shadow of the bitmap, counters and cluster total, plus the replies owed
  class cluster_map_scoreboard;
    bit [7:0]     map_bytes [MAP_BYTES];
    bit [16:0]    used_count;
    bit [31:0]    search_ptr;
    bit [16:0]    total_reg;
    alloc_reply_t replies_due [$];
    int           errors;

    function new();
      foreach (map_bytes[i]) map_bytes[i] = 8'h00;
      used_count = '0;
      search_ptr = FIRST_DATA;
      total_reg  = 17'd65538;
      errors     = 0;
    endfunction

    // register value clamped to what the bitmap can hold
    function int unsigned clamped_total();
      int unsigned t;
      t = 32'(total_reg);
      if (t < FIRST_DATA) t = FIRST_DATA;
      if (t > MAP_CLUSTERS + FIRST_DATA) t = MAP_CLUSTERS + FIRST_DATA;
      return t;
    endfunction

    function bit map_bit(int unsigned idx);
      return map_bytes[idx >> 3][idx % 8];
    endfunction

    function void note_request(alloc_req_t req);
      int unsigned  total;
      int unsigned  data;
      int unsigned  scan_from;
      int unsigned  idx;
      int unsigned  hits;
      bit           found;
      alloc_reply_t rsp;
      total = clamped_total();
      data  = total - FIRST_DATA;
      rsp   = '{STATUS_OK, 32'd0, used_count};
      found = 1'b0;
      case (req.opcode)
        OP_ALLOC: begin
          if (req.hint >= FIRST_DATA && req.hint < total) scan_from = req.hint;
          else if (search_ptr >= FIRST_DATA && search_ptr < total) scan_from = search_ptr;
          else scan_from = FIRST_DATA;
          // a full count gives no space without a scan
          if (used_count < data) begin
            idx = scan_from - FIRST_DATA;
            for (int unsigned k = 0; k < data; k++) begin
              if (!map_bit(idx)) begin
                found = 1'b1;
                break;
              end
              idx = (idx + 1 == data) ? 0 : idx + 1;
            end
          end
          if (found) begin
            map_bytes[idx >> 3][idx % 8] = 1'b1;
            used_count++;
            rsp.cluster = idx + FIRST_DATA;
            search_ptr  = rsp.cluster;
            rsp.used    = used_count;
          end else begin
            rsp.status  = STATUS_NO_SPACE;
            rsp.cluster = NO_CLUSTER;
          end
        end
        OP_FREE: begin
          if (req.cluster < FIRST_DATA || req.cluster >= total) begin
            rsp.status = STATUS_RANGE;
          end else begin
            // count drops even when the bit was already clear
            idx = req.cluster - FIRST_DATA;
            map_bytes[idx >> 3][idx % 8] = 1'b0;
            if (used_count != 0) used_count--;
            rsp.used = used_count;
          end
        end
        OP_COUNT: begin
          hits = 0;
          for (int unsigned i = 0; i < data; i++) hits += 32'(map_bit(i));
          rsp.used = 17'(hits);
        end
        OP_LOAD: begin
          // every 13-bit index lands inside the bitmap
          map_bytes[req.byte_index] = req.byte_value;
        end
      endcase
      replies_due.push_back(rsp);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    endtask

    task check_result(alloc_reply_t got);
      alloc_reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("result with no request outstanding", got.cluster, 32'd0);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.cluster !== want.cluster)
        report_mismatch("result_cluster", got.cluster, want.cluster);
      if (got.used !== want.used) report_mismatch("used_total", got.used, want.used);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [31:0] cluster;
  logic [31:0] hint;
  logic [12:0] byte_index;
  logic [7:0]  byte_value;
  logic        cfg_we;
  logic [16:0] cfg_data;
  logic        done;
  logic [1:0]  status;
  logic [31:0] result_cluster;
  logic [16:0] used_total;

  cluster_map_scoreboard sb;
  int unsigned           idle_pct;
  int unsigned           stall_cycles;

  // random part: cluster total and request count per segment
  // small totals fill up and reach the no-space paths, big ones exercise long scans
  int unsigned seg_total [14] = '{10, 3, 65538, 40, 2, 131071, 130, 9, 1, 17, 65537, 0,
                                  300, 6};
  int unsigned seg_len [14]   = '{30, 28, 12, 30, 6, 12, 30, 28, 6, 30, 12, 6, 30, 28};

  cluster_bitmap_allocator_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .cluster        (cluster),
    .hint           (hint),
    .byte_index     (byte_index),
    .byte_value     (byte_value),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .result_cluster (result_cluster),
    .used_total     (used_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result monitor: every done pulse is checked against the oldest reply owed
  // the stall counter restarts whenever a request or a result is taken
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) sb.check_result(alloc_reply_t'{status, result_cluster, used_total});
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // watchdog on a hung handshake or a missing result
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // one request: optional idle gap, then hold start until busy is low at an edge
  // start is left high on return so back-to-back requests never glitch it
  task automatic send(alloc_req_t req);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= req.opcode;
    cluster    <= req.cluster;
    hint       <= req.hint;
    byte_index <= req.byte_index;
    byte_value <= req.byte_value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(req);
  endtask

  // drop start and wait for every owed reply
  task automatic drain_replies();
    start <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  // cluster total only changes with no reply owed
  task automatic write_total(bit [16:0] value);
    drain_replies();
    cfg_we       <= 1'b1;
    cfg_data     <= value;
    sb.total_reg  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic alloc_req_t mk_req(logic [1:0] op, logic [31:0] clu, logic [31:0] hnt,
                                        logic [12:0] bidx = '0, logic [7:0] bval = '0);
    return '{op, clu, hnt, bidx, bval};
  endfunction

  // cluster numbers around the range boundaries
  function automatic logic [31:0] edge_cluster(int unsigned total);
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd1;
      2: return total - 1;
      3: return total;
      default: return NO_CLUSTER;
    endcase
  endfunction

  // mostly well-formed traffic: allocs and in-range frees, some counts and loads,
  // with boundary and fully random cluster/hint values mixed in
  function automatic alloc_req_t rand_request();
    alloc_req_t  req;
    int unsigned total;
    int unsigned data;
    int unsigned pick;
    total          = sb.clamped_total();
    data           = total - FIRST_DATA;
    req.cluster    = $urandom;
    req.hint       = $urandom;
    req.byte_index = 13'($urandom);
    req.byte_value = 8'($urandom);
    pick           = $urandom_range(0, 99);
    if (pick < 45) begin
      req.opcode = OP_ALLOC;
      case ($urandom_range(0, 3))
        0, 1: if (data != 0) req.hint = $urandom_range(FIRST_DATA, total - 1);
        2: req.hint = edge_cluster(total);
        default: ;
      endcase
    end else if (pick < 75) begin
      req.opcode = OP_FREE;
      case ($urandom_range(0, 5))
        0: req.cluster = edge_cluster(total);
        1: ;
        default: if (data != 0) req.cluster = $urandom_range(FIRST_DATA, total - 1);
      endcase
    end else if (pick < 87) begin
      req.opcode = OP_COUNT;
    end else begin
      req.opcode = OP_LOAD;
      // usually a byte that holds live data bits
      if (data != 0 && $urandom_range(0, 3) != 0)
        req.byte_index = 13'($urandom_range(0, (data - 1) / 8));
    end
    return req;
  endfunction

  initial begin
    sb         = new();
    idle_pct   = 31;
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_ALLOC;
    cluster    = '0;
    hint       = '0;
    byte_index = '0;
    byte_value = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full-size map, first requests wait out the clearing pass
    write_total(17'd65538);
    send(mk_req(OP_ALLOC, 32'd0, 32'd0));          // bad hint, pointer at cluster 2
    send(mk_req(OP_ALLOC, 32'd0, 32'd65537));      // last data cluster
    send(mk_req(OP_ALLOC, 32'd0, NO_CLUSTER));     // scan wraps past the end
    send(mk_req(OP_ALLOC, 32'd0, 32'd65538));      // hint one past the end
    send(mk_req(OP_FREE, 32'd0, 32'd0));           // reserved clusters and past the end
    send(mk_req(OP_FREE, 32'd1, 32'd0));
    send(mk_req(OP_FREE, 32'd65538, 32'd0));
    send(mk_req(OP_FREE, 32'd65537, 32'd0));
    send(mk_req(OP_FREE, 32'd65537, 32'd0));       // bit already clear, count still drops
    send(mk_req(OP_LOAD, 32'd0, 32'd0, 13'd8191, 8'hFF));
    send(mk_req(OP_LOAD, 32'd0, 32'd0, 13'd0, 8'hA5));
    send(mk_req(OP_COUNT, 32'd0, 32'd0));
    send(mk_req(OP_FREE, 32'd2, 32'd0));
    send(mk_req(OP_FREE, 32'd3, 32'd0));
    send(mk_req(OP_FREE, 32'd4, 32'd0));           // count saturates at zero

    // eight data clusters: only the last one free, then none free
    write_total(17'd10);
    send(mk_req(OP_LOAD, 32'd0, 32'd0, 13'd0, 8'h7F));
    send(mk_req(OP_ALLOC, 32'd0, 32'd0));
    send(mk_req(OP_ALLOC, 32'd0, 32'd0));          // count below size, but no clear bit

    // one data cluster: count already full, then free and reuse
    write_total(17'd3);
    send(mk_req(OP_ALLOC, 32'd0, 32'd0));
    send(mk_req(OP_FREE, 32'd2, 32'd0));
    send(mk_req(OP_ALLOC, 32'd0, 32'd0));          // hint and pointer both out, start at 2

    // zero data clusters
    write_total(17'd0);
    send(mk_req(OP_ALLOC, 32'd0, 32'd2));
    send(mk_req(OP_FREE, 32'd2, 32'd0));
    send(mk_req(OP_COUNT, 32'd0, 32'd0));

    // register above the map size clamps to the full map
    write_total(17'h1FFFF);
    send(mk_req(OP_COUNT, 32'd0, 32'd0));

    // random segments: sender idling light, heavy, then none
    for (int s = 0; s < 14; s++) begin
      idle_pct = (s < 5) ? 31 : ((s < 10) ? 88 : 0);
      write_total(17'(seg_total[s]));
      repeat (seg_len[s]) send(rand_request());
    end

    drain_replies();
    // catch any stray result after the last one
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
